@@ rtl/core/hbps_pkg.sv @@
// haptic beep pattern sequencer: shared types and constants
// payload structs, pattern and register codes, scale unit request/response
`timescale 1ns / 1ps

package hbps_pkg;

  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    PAT_NONE = 3'd0,
    PAT_DUTY = 3'd1,
    PAT_CONT = 3'd2,
    PAT_TEMP = 3'd3,
    PAT_VOLT = 3'd4
  } hbps_pattern_e;

  localparam logic [2:0] RSN_DUTY      = 3'd1;
  localparam logic [2:0] RSN_TEMP      = 3'd2;
  localparam logic [2:0] RSN_LOW_VOLT  = 3'd3;
  localparam logic [2:0] RSN_HIGH_VOLT = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_THR  = 3'd0,
    CFG_CUR_THR   = 3'd1,
    CFG_TONE_LEN  = 3'd2,
    CFG_DUTY_TONE = 3'd3,
    CFG_ERR_TONE  = 3'd4,
    CFG_VIB_TONE  = 3'd5,
    CFG_STR_MIN   = 3'd6,
    CFG_STR_COEF  = 3'd7
  } hbps_cfg_e;

  typedef struct packed {
    logic        running;
    logic        handtest_mode;
    logic [2:0]  pushback_reason;
    logic [15:0] motor_duty;
    logic [15:0] current_saturation;
    logic [15:0] speed;
  } hbps_in_t;

  typedef struct packed {
    logic [2:0]  pattern;
    logic        tone_active;
    logic [15:0] tone_frequency;
    logic [15:0] tone_amplitude;
    logic        vibrate_active;
    logic [15:0] vibrate_frequency;
    logic [15:0] vibrate_amplitude;
    logic        stop_tones;
  } hbps_out_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] strength_min;
    logic [15:0] coef_b;
    logic [15:0] coef_c;
    logic [15:0] tone_strength;
    logic [15:0] vib_strength;
  } hbps_scale_req_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic [15:0] tone_amp;
    logic [15:0] vib_amp;
  } hbps_scale_rsp_t;

endpackage

@@ rtl/core/hbps_scale_unit.sv @@
// speed scale and amplitude unit around one shared 17x33 signed multiplier
// depends on hbps_pkg for the request and response structs
`timescale 1ns / 1ps

module hbps_scale_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  hbps_pkg::hbps_scale_req_t req_i,
  input  logic                    take_i,
  output hbps_pkg::hbps_scale_rsp_t rsp_o
);
  import hbps_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_CSQ   = 9'b000000100,
    S_BS    = 9'b000001000,
    S_SUM   = 9'b000010000,
    S_CLAMP = 9'b000100000,
    S_TAMP  = 9'b001000000,
    S_VAMP  = 9'b010000000,
    S_DONE  = 9'b100000000
  } hbps_scale_state_e;

  hbps_scale_state_e      state_q, state_d;
  hbps_scale_req_t        req_q;
  logic signed [49:0]     prod_q, acc_q, acc_d;
  logic signed [16:0]     op_a;
  logic signed [32:0]     op_b;
  logic signed [49:0]     prod;
  logic [16:0]            scale_q, scale_d;
  logic [15:0]            tone_amp_q;

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    acc_d   = acc_q;
    scale_d = scale_q;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SQ;
      end
      S_SQ: begin
        op_a    = $signed({req_q.speed[15], req_q.speed});
        op_b    = $signed({{17{req_q.speed[15]}}, req_q.speed});
        state_d = S_CSQ;
      end
      S_CSQ: begin
        op_a    = $signed({req_q.coef_c[15], req_q.coef_c});
        op_b    = $signed(prod_q[32:0]);
        state_d = S_BS;
      end
      S_BS: begin
        op_a    = $signed({req_q.coef_b[15], req_q.coef_b});
        op_b    = $signed({{17{req_q.speed[15]}}, req_q.speed});
        acc_d   = $signed({18'b0, req_q.strength_min, 16'b0}) + prod_q;
        state_d = S_SUM;
      end
      S_SUM: begin
        acc_d   = acc_q + $signed({prod_q[41:0], 8'b0});
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        if (acc_q <= 50'sd0) begin
          scale_d = '0;
        end else if (acc_q >= $signed(50'h1_0000_0000)) begin
          scale_d = 17'h1_0000;
        end else begin
          scale_d = {1'b0, acc_q[31:16]};
        end
        state_d = S_TAMP;
      end
      S_TAMP: begin
        op_a    = $signed({1'b0, req_q.tone_strength});
        op_b    = $signed({16'b0, scale_q});
        state_d = S_VAMP;
      end
      S_VAMP: begin
        op_a    = $signed({1'b0, req_q.vib_strength});
        op_b    = $signed({16'b0, scale_q});
        state_d = S_DONE;
      end
      S_DONE: begin
        if (take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) req_q <= req_i;
    if (state_q != S_IDLE && state_q != S_DONE) prod_q <= prod;
    acc_q   <= acc_d;
    scale_q <= scale_d;
    if (state_q == S_VAMP) tone_amp_q <= prod_q[31:16];
  end

  assign rsp_o.idle     = (state_q == S_IDLE);
  assign rsp_o.done     = (state_q == S_DONE);
  assign rsp_o.tone_amp = tone_amp_q;
  assign rsp_o.vib_amp  = prod_q[31:16];

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("scale unit started while busy");

  a_scale_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAMP |-> scale_q <= 17'h1_0000)
    else $error("speed scale above one");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && take_i) |=> state_q == S_IDLE)
    else $error("scale unit did not release after take");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !take_i) |=> (state_q == S_DONE && $stable(prod_q)))
    else $error("scale result changed while waiting");

endmodule

@@ rtl/core/haptic_beep_pattern_sequencer.sv @@
// haptic beep pattern sequencer top level: config registers, pattern state, result register
// depends on hbps_pkg and hbps_scale_unit
`timescale 1ns / 1ps

// One request is one control tick. The tick is classified and the pattern, beat and
// playing state are updated in the cycle it is taken; the speed scale and the two
// amplitudes then go through one shared 17x33 multiplier in eight sequencer steps
// (speed squared, quadratic term, linear term, sum, clamp, tone amplitude, vibration
// amplitude, hand-off). The result waits in the hand-off step while the output side
// is stalled and then moves into the output register; the next request is taken only
// once the scale unit is idle again, so a new tick is not taken while one is in
// flight. The user must write configuration only while no tick is in flight; the
// block itself does not enforce this.
module haptic_beep_pattern_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hbps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hbps_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  hbps_pkg::hbps_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output hbps_pkg::hbps_out_t                  out_data_o
);
  import hbps_pkg::*;

  logic [15:0] duty_thr_q, cur_thr_q, tone_len_q, str_min_q;
  logic [31:0] duty_tone_q, err_tone_q, vib_tone_q, str_coef_q;

  hbps_pattern_e     pat_q, pat_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  logic [15:0]       phase_q, phase_d;
  logic [2:0]        index_q, index_d;
  logic              flag_q, flag_d;

  hbps_pattern_e item_pat_q;
  logic          item_should_q, item_stop_q;
  logic [31:0]   item_word_q;

  logic        out_valid_q;
  hbps_out_t   out_q;

  hbps_scale_req_t scale_req;
  hbps_scale_rsp_t scale_rsp;
  logic            in_accept, take;

  hbps_pattern_e     want, cur_pat;
  logic              do_switch, should, stop;
  logic [15:0]       len;
  logic [3:0]        beats, off;
  logic [TICK_W-1:0] elapsed_cur;
  logic [15:0]       phase_cur;
  logic [2:0]        index_cur;
  logic [16:0]       phase_inc;
  logic [3:0]        index_inc;
  logic [31:0]       word;
  logic              tone_on, vib_on;
  hbps_out_t         out_d;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = !scale_rsp.idle;
  assign take = scale_rsp.done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_thr_q  <= 16'd29491;
      cur_thr_q   <= 16'd0;
      tone_len_q  <= 16'd100;
      duty_tone_q <= 32'd0;
      err_tone_q  <= 32'd0;
      vib_tone_q  <= 32'd0;
      str_min_q   <= 16'd65535;
      str_coef_q  <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DUTY_THR:  duty_thr_q  <= cfg_wdata_i[15:0];
        CFG_CUR_THR:   cur_thr_q   <= cfg_wdata_i[15:0];
        CFG_TONE_LEN:  tone_len_q  <= cfg_wdata_i[15:0];
        CFG_DUTY_TONE: duty_tone_q <= cfg_wdata_i;
        CFG_ERR_TONE:  err_tone_q  <= cfg_wdata_i;
        CFG_VIB_TONE:  vib_tone_q  <= cfg_wdata_i;
        CFG_STR_MIN:   str_min_q   <= cfg_wdata_i[15:0];
        CFG_STR_COEF:  str_coef_q  <= cfg_wdata_i;
      endcase
    end
  end

  // classify, switch, beat decision and state advance for one tick
  always_comb begin
    len = (tone_len_q == 16'd0) ? 16'd1 : tone_len_q;

    priority if (!in_data_i.running || in_data_i.handtest_mode) begin
      want = PAT_NONE;
    end else if (in_data_i.pushback_reason == RSN_DUTY) begin
      want = ($signed(in_data_i.motor_duty) > $signed(duty_thr_q)) ? PAT_CONT : PAT_DUTY;
    end else if (in_data_i.pushback_reason == RSN_TEMP) begin
      want = PAT_TEMP;
    end else if (in_data_i.pushback_reason == RSN_LOW_VOLT ||
                 in_data_i.pushback_reason == RSN_HIGH_VOLT) begin
      want = PAT_VOLT;
    end else if (cur_thr_q != 16'd0 && in_data_i.current_saturation > cur_thr_q) begin
      want = PAT_CONT;
    end else begin
      want = PAT_NONE;
    end

    do_switch = (want != pat_q) &&
                ({{(33-TICK_W){1'b0}}, elapsed_q} > {17'b0, len});
    cur_pat     = do_switch ? want : pat_q;
    elapsed_cur = do_switch ? '0 : elapsed_q;
    phase_cur   = do_switch ? 16'd0 : phase_q;
    index_cur   = do_switch ? 3'd0 : index_q;

    unique case (cur_pat)
      PAT_DUTY: beats = 4'd2;
      PAT_TEMP: beats = 4'd6;
      PAT_VOLT: beats = 4'd8;
      default:  beats = 4'd0;
    endcase
    off = (beats > 4'd2) ? beats - 4'd2 : 4'd0;

    should = (cur_pat != PAT_NONE) &&
             ((beats == 4'd0) ||
              (!index_cur[0] && (off == 4'd0 || {1'b0, index_cur} != off)));
    stop = flag_q && !should;

    unique case (cur_pat)
      PAT_DUTY, PAT_CONT: word = duty_tone_q;
      PAT_TEMP, PAT_VOLT: word = err_tone_q;
      default:            word = 32'd0;
    endcase

    flag_d = stop ? 1'b0 : (should ? 1'b1 : flag_q);
    pat_d  = cur_pat;
    elapsed_d = (elapsed_cur != {TICK_W{1'b1}}) ? elapsed_cur + 1'b1 : elapsed_cur;

    phase_inc = {1'b0, phase_cur} + 17'd1;
    index_inc = {1'b0, index_cur} + 4'd1;
    if (phase_inc >= {1'b0, len}) begin
      phase_d = 16'd0;
      if (beats == 4'd0 || index_inc >= beats) index_d = 3'd0;
      else index_d = index_inc[2:0];
    end else begin
      phase_d = phase_inc[15:0];
      index_d = index_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= PAT_NONE;
      elapsed_q <= '0;
      phase_q   <= '0;
      index_q   <= '0;
      flag_q    <= 1'b0;
    end else if (in_accept) begin
      pat_q     <= pat_d;
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
      index_q   <= index_d;
      flag_q    <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_pat_q    <= cur_pat;
      item_should_q <= should;
      item_stop_q   <= stop;
      item_word_q   <= word;
    end
  end

  assign scale_req.speed         = in_data_i.speed;
  assign scale_req.strength_min  = str_min_q;
  assign scale_req.coef_b        = str_coef_q[31:16];
  assign scale_req.coef_c        = str_coef_q[15:0];
  assign scale_req.tone_strength = word[15:0];
  assign scale_req.vib_strength  = vib_tone_q[15:0];

  hbps_scale_unit u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .req_i   (scale_req),
    .take_i  (take),
    .rsp_o   (scale_rsp)
  );

  always_comb begin
    tone_on = item_should_q && (item_word_q[15:0] != 16'd0);
    vib_on  = item_should_q && (vib_tone_q[15:0] != 16'd0);
    out_d.pattern           = item_pat_q;
    out_d.tone_active       = tone_on;
    out_d.tone_frequency    = tone_on ? item_word_q[31:16] : 16'd0;
    out_d.tone_amplitude    = tone_on ? scale_rsp.tone_amp : 16'd0;
    out_d.vibrate_active    = vib_on;
    out_d.vibrate_frequency = vib_on ? vib_tone_q[31:16] : 16'd0;
    out_d.vibrate_amplitude = vib_on ? scale_rsp.vib_amp : 16'd0;
    out_d.stop_tones        = item_stop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled while a request is in flight");

  a_stop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.stop_tones) |->
      (!out_data_o.tone_active && !out_data_o.vibrate_active))
    else $error("stop pulse with a tone still active");

endmodule
